FILE: rtl/core/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Operation codes on the kind field
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  // Occupancy is reported in a fixed 7-bit field
  localparam int OCC_W = 7;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CMP
  } state_t;

endpackage

FILE: rtl/core/min_heap_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// Binary min-heap of key/value pairs held in one dual-read RAM.
// ----------------------------------------------------------------------------
// Results: an insert result strobes in the cycle after the request is taken;
//   an extract result follows S_DN_LOAD reading the root. done is high for one
//   cycle only. start is taken only while busy is low; busy stays high while
//   the sift walks the tree, one level per cycle (RAM read, compare, write).
// Reset: rst clears the entry count and control; the pair store is not
//   cleared, only slots below the count are ever used.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // request side
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [KEY_BITS-1:0]       in_key,
  input  logic [VALUE_BITS-1:0]     in_value,
  // result side, one strobe per request, cannot be stalled
  output logic                      done,
  output logic [KEY_BITS-1:0]       out_key,
  output logic [VALUE_BITS-1:0]     out_value,
  output mhpq_pkg::status_t         status,
  output logic [mhpq_pkg::OCC_W-1:0] occupancy
);

  import mhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);      // slot index
  localparam int CW = $clog2(DEPTH + 1);  // entry count, holds DEPTH itself
  localparam int XW = AW + 2;             // child index before range check
  localparam int W  = KEY_BITS + VALUE_BITS;

  // --------------------------------------------------------------------------
  // Control and carried-item registers
  // The item being sifted never sits in the RAM until it settles: the RAM
  // holds a hole at 'hole' and the pair is written once at the end.
  // --------------------------------------------------------------------------
  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         hole, hole_next;
  logic [KEY_BITS-1:0]   item_key, item_key_next;
  logic [VALUE_BITS-1:0] item_val, item_val_next;

  // result staging
  logic                  emit;
  status_t               res_status;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_val;
  logic [CW-1:0]         res_occ;

  // RAM port signals
  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [W-1:0]  wdata, rdata_a, rdata_b;

  mhpq_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic                  accept;
  logic                  is_full, is_empty;
  logic [KEY_BITS-1:0]   a_key, b_key, best_key;
  logic [VALUE_BITS-1:0] a_val, b_val, best_val;
  logic [AW:0]           left_raw, best_raw;
  logic [XW-1:0]         left_x, right_x, count_x;
  logic                  left_ok, right_ok, pick_right;
  logic [AW-1:0]         left_idx, right_idx, best_idx, parent_idx, gparent_idx;
  logic                  up_swap, dn_swap;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  assign a_key = rdata_a[W-1:VALUE_BITS];
  assign a_val = rdata_a[VALUE_BITS-1:0];
  assign b_key = rdata_b[W-1:VALUE_BITS];
  assign b_val = rdata_b[VALUE_BITS-1:0];

  // sift-up: port A returns the parent of the hole
  assign parent_idx  = (hole - AW'(1)) >> 1;
  assign gparent_idx = (parent_idx - AW'(1)) >> 1;
  assign up_swap     = (item_key < a_key);

  // sift-down: port A left child, port B right child; bounds against count
  assign left_raw   = {hole, 1'b1};
  assign left_x     = XW'(left_raw);
  assign right_x    = left_x + XW'(1);
  assign count_x    = XW'(count);
  assign left_ok    = (left_x < count_x);
  assign right_ok   = (right_x < count_x);
  assign left_idx   = left_x[AW-1:0];
  assign right_idx  = right_x[AW-1:0];
  // equal children: left wins
  assign pick_right = right_ok && (b_key < a_key);
  assign best_key   = pick_right ? b_key : a_key;
  assign best_val   = pick_right ? b_val : a_val;
  assign best_idx   = pick_right ? right_idx : left_idx;
  assign dn_swap    = left_ok && (best_key < item_key);
  assign best_raw   = {best_idx, 1'b1};

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_INSERT) begin
            if (!is_full && !is_empty) begin
              state_next = S_UP_CMP;
            end
          end else if (!is_empty) begin
            state_next = S_DN_LOAD;
          end
        end
      end
      S_UP_CMP: begin
        if (hole == '0 || !up_swap) begin
          state_next = S_IDLE;
        end
      end
      S_DN_LOAD: begin
        // count already holds the decremented value
        if (count == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (!dn_swap) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: RAM control, carried item, results
  // --------------------------------------------------------------------------
  always_comb begin
    we            = 1'b0;
    waddr         = hole;
    wdata         = {item_key, item_val};
    raddr_a       = '0;
    raddr_b       = '0;
    count_next    = count;
    hole_next     = hole;
    item_key_next = item_key;
    item_val_next = item_val;
    emit          = 1'b0;
    res_status    = STATUS_OK;
    res_key       = '0;
    res_val       = '0;
    res_occ       = count;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          if (kind == KIND_INSERT) begin
            if (is_full) begin
              res_status = STATUS_FULL;
            end else begin
              count_next    = count + CW'(1);
              res_occ       = count + CW'(1);
              hole_next     = count[AW-1:0];
              item_key_next = in_key;
              item_val_next = in_value;
              if (is_empty) begin
                // first pair goes straight to the root
                we    = 1'b1;
                waddr = '0;
                wdata = {in_key, in_value};
              end else begin
                raddr_a = (count[AW-1:0] - AW'(1)) >> 1;
              end
            end
          end else begin
            if (is_empty) begin
              res_status = STATUS_EMPTY;
            end else begin
              // result goes out once the root has been read
              emit       = 1'b0;
              count_next = count - CW'(1);
              raddr_a    = '0;
              raddr_b    = AW'(count - CW'(1));
            end
          end
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (hole != '0 && up_swap) begin
          // parent moves down into the hole, hole climbs
          waddr     = hole;
          wdata     = rdata_a;
          hole_next = parent_idx;
          raddr_a   = gparent_idx;
        end
      end
      S_DN_LOAD: begin
        // A: root being returned, B: last pair, now carried from the root
        emit          = 1'b1;
        res_key       = a_key;
        res_val       = a_val;
        res_occ       = count;
        item_key_next = b_key;
        item_val_next = b_val;
        hole_next     = '0;
        raddr_a       = AW'(1);
        raddr_b       = AW'(2);
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (dn_swap) begin
          // smaller child moves up, hole sinks
          waddr     = hole;
          wdata     = {best_key, best_val};
          hole_next = best_idx;
          raddr_a   = best_raw[AW-1:0];
          raddr_b   = AW'(best_raw + (AW + 1)'(1));
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    hole     <= hole_next;
    item_key <= item_key_next;
    item_val <= item_val_next;
    if (emit) begin
      out_key   <= res_key;
      out_value <= res_val;
      status    <= res_status;
      occupancy <= OCC_W'(res_occ);
    end
  end

endmodule

FILE: rtl/core/mhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM, one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
